FILE: rtl/pda_pkg.sv
`timescale 1ns / 1ps
package pda_pkg;

	localparam int COUNT_FRAC_BITS = 16;
	localparam int LOG_TABLE_BITS  = 8;
	localparam int LOG_TABLE_DEPTH = 1 << LOG_TABLE_BITS;
	localparam int COUNT_W         = 32;
	localparam int ENERGY_W        = 16;
	localparam int SUM_W           = 56;
	localparam int TERM_W          = 42;
	localparam int LN_W            = 31;
	localparam int LOGT_W          = 24;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;

	localparam logic [LOGT_W-1:0] LN2_Q24 = 24'd11629080;
	localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_CUT_EN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_E_HIGH_CUT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_E_LOW_CUT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MU_LOW_CUT   = 3'd3;

	typedef logic [LOGT_W-1:0] log_table_t [0:LOG_TABLE_DEPTH];

	// long division for the table constants, shift and subtract
	function automatic logic [63:0] const_udiv(logic [63:0] num, logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// ln(1 + i/depth) in q0.24 through the atanh series, worked out at elaboration
	function automatic log_table_t build_log_table();
		log_table_t  tab;
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] pw;
		logic [63:0] acc;
		logic [63:0] rnd;
		for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
			u   = const_udiv(64'(i) << 30, 64'(2 * LOG_TABLE_DEPTH) + 64'(i));
			u2  = (u * u) >> 30;
			pw  = u;
			acc = '0;
			for (int k = 0; k < 40; k++) begin
				if (pw != 64'd0) begin
					acc = acc + const_udiv(pw, 64'(2 * k + 1));
					pw  = (pw * u2) >> 30;
				end
			end
			rnd    = (64'd2 * acc + 64'd32) >> 6;
			tab[i] = rnd[LOGT_W-1:0];
		end
		return tab;
	endfunction

	localparam log_table_t LOG_TABLE = build_log_table();

	typedef struct packed {
		logic load;
		logic check;
		logic ln1;
		logic ln2;
		logic sel_p;
		logic mul;
		logic term;
		logic acc;
	} pda_cmd_t;

	typedef struct packed {
		logic bypass;
		logic last;
	} pda_status_t;

endpackage

FILE: rtl/poisson_deviance_accumulator_core.sv
`timescale 1ns / 1ps
// poisson deviance accumulator
// input channel (in_valid/in_ready) takes one histogram bin per beat: sample
// kind, bin energy, observed and predicted counts (q16.16) and a last-bin mark.
// output channel (out_valid/out_ready) gives one beat per run, on the last
// bin: the saturating q40.16 deviance sum and a flag set if it saturated.
// cut registers are written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, which the block does not enforce. a bin with both
// counts nonzero goes through idle, the check, one shared log unit (two stages)
// run once for each count, one 32x31 multiply, the term and the accumulate;
// skipped or empty bins go from the check to the accumulate. no bin is taken
// while one is in flight; the result registers at the last bin's accumulate.
// reset clears the sum, the flag, any pending result and restores cut
// defaults; the log table is a constant and needs no fill.
// a stalled result register holds its beat; further bins are still taken
// and only a following last bin waits at its accumulate step.
module poisson_deviance_accumulator_core import pda_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  sample_kind,
	input  logic [ENERGY_W-1:0]   bin_energy,
	input  logic [COUNT_W-1:0]    observed_count,
	input  logic [COUNT_W-1:0]    predicted_count,
	input  logic                  last_bin,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SUM_W-1:0]      total_deviance,
	output logic                  saturated
);

	pda_cmd_t    cmd;
	pda_status_t status;

	pda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	pda_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample_kind     (sample_kind),
		.bin_energy      (bin_energy),
		.observed_count  (observed_count),
		.predicted_count (predicted_count),
		.last_bin        (last_bin),
		.cmd             (cmd),
		.status          (status),
		.total_deviance  (total_deviance),
		.saturated       (saturated)
	);

	// a beat taken closes the input until the bin is done
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a bin is in flight");

	// a stalled result holds its value
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_deviance) && $stable(saturated))
		else $error("result changed under stall");

	// the flag only comes with a pinned sum
	a_sat_pinned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> total_deviance == SUM_MAX)
		else $error("saturated without full-scale sum");

endmodule

FILE: rtl/pda_datapath.sv
`timescale 1ns / 1ps
module pda_datapath import pda_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  sample_kind,
	input  logic [ENERGY_W-1:0]   bin_energy,
	input  logic [COUNT_W-1:0]    observed_count,
	input  logic [COUNT_W-1:0]    predicted_count,
	input  logic                  last_bin,
	input  pda_cmd_t              cmd,
	output pda_status_t           status,
	output logic [SUM_W-1:0]      total_deviance,
	output logic                  saturated
);

	logic                high_cut_en_q;
	logic [ENERGY_W-1:0] e_high_cut_q;
	logic [ENERGY_W-1:0] e_low_cut_q;
	logic [ENERGY_W-1:0] mu_low_cut_q;

	logic                kind_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [COUNT_W-1:0]  obs_q;
	logic [COUNT_W-1:0]  pred_q;
	logic                last_q;

	logic signed [LN_W-1:0]   eterm_s1;
	logic [LOGT_W-1:0]        lo_s1;
	logic [LOGT_W-1:0]        hi_s1;
	logic [30:0]              r_s1;
	logic signed [LN_W-1:0]   ln_o_q;
	logic signed [LN_W:0]     d_q;
	logic [62:0]              mag_q;
	logic                     neg_q;
	logic [TERM_W-1:0]        term_q;
	logic [SUM_W-1:0]         sum_q;
	logic                     ovf_q;
	logic [SUM_W-1:0]         tot_q;
	logic                     sat_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_cut_en_q <= 1'b1;
			e_high_cut_q  <= 16'd1200;
			e_low_cut_q   <= 16'd100;
			mu_low_cut_q  <= 16'd200;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HIGH_CUT_EN: high_cut_en_q <= cfg_data[0];
				REG_E_HIGH_CUT:  e_high_cut_q  <= cfg_data;
				REG_E_LOW_CUT:   e_low_cut_q   <= cfg_data;
				REG_MU_LOW_CUT:  mu_low_cut_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// bin capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= sample_kind;
			energy_q <= bin_energy;
			obs_q    <= observed_count;
			pred_q   <= predicted_count;
			last_q   <= last_bin;
		end
	end

	// energy cuts and empty counts
	logic skip;
	always_comb begin
		if (!kind_q)
			skip = (high_cut_en_q && (energy_q > e_high_cut_q)) || (energy_q < e_low_cut_q);
		else
			skip = energy_q < mu_low_cut_q;
	end
	assign status.bypass = skip || (obs_q == '0) || (pred_q == '0);
	assign status.last   = last_q;

	// log stage one: leading one, normalise, table read
	logic [COUNT_W-1:0] ln_x;
	logic [4:0]         lead;
	logic [COUNT_W-1:0] norm;
	logic [30:0]        frac;
	logic [LOG_TABLE_BITS-1:0] tidx;
	logic [LOG_TABLE_BITS:0]   tidx_n;
	logic signed [6:0]  eoff;
	always_comb begin
		ln_x = cmd.sel_p ? pred_q : obs_q;
		lead = '0;
		for (int b = 0; b < COUNT_W; b++)
			if (ln_x[b]) lead = 5'(b);
		norm   = ln_x << (5'd31 - lead);
		frac   = norm[30:0];
		tidx   = frac[30 -: LOG_TABLE_BITS];
		tidx_n = {1'b0, tidx} + 1'b1;
		eoff   = $signed({2'b00, lead}) - 7'(COUNT_FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (cmd.ln1) begin
			eterm_s1 <= LN_W'(LN_W'(eoff) * $signed({1'b0, LN2_Q24}));
			lo_s1    <= LOG_TABLE[tidx];
			hi_s1    <= LOG_TABLE[tidx_n];
			r_s1     <= frac << LOG_TABLE_BITS;
		end
	end

	// log stage two: interpolate
	logic [LOGT_W-1:0]      diff;
	logic [54:0]            prod;
	logic [LOGT_W-1:0]      interp;
	logic signed [LN_W-1:0] ln_val;
	always_comb begin
		diff   = (hi_s1 >= lo_s1) ? hi_s1 - lo_s1 : '0;
		prod   = 55'(diff) * 55'(r_s1);
		interp = lo_s1 + prod[54:31];
		ln_val = eterm_s1 + $signed({7'd0, interp});
	end

	// ratio magnitude and final term
	logic [LN_W:0]          abs_d;
	logic [38:0]            qv;
	logic [63:0]            qsum;
	logic signed [TERM_W:0] tval;
	always_comb begin
		abs_d = d_q[LN_W] ? LN_W'(0) - d_q : d_q;
		qsum  = 64'(mag_q) + 64'h80_0000;
		qv    = qsum[62:24];
		tval  = $signed({11'd0, pred_q}) - $signed({11'd0, obs_q})
			+ (neg_q ? -$signed({4'd0, qv}) : $signed({4'd0, qv}));
	end

	// saturating accumulate
	logic [SUM_W:0]   sum_ext;
	logic [SUM_W-1:0] sum_nx;
	logic             ovf_nx;
	always_comb begin
		sum_ext = {1'b0, sum_q} + (SUM_W+1)'(term_q);
		if (sum_ext >= {1'b0, SUM_MAX}) begin
			sum_nx = SUM_MAX;
			ovf_nx = 1'b1;
		end else begin
			sum_nx = sum_ext[SUM_W-1:0];
			ovf_nx = ovf_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ln2 && !cmd.sel_p) ln_o_q <= ln_val;
		if (cmd.ln2 && cmd.sel_p)  d_q <= $signed({ln_o_q[LN_W-1], ln_o_q})
			- $signed({ln_val[LN_W-1], ln_val});
		if (cmd.mul) begin
			mag_q <= 63'(obs_q) * 63'(abs_d);
			neg_q <= d_q[LN_W];
		end
		if (cmd.check) begin
			if (skip || pred_q == '0) term_q <= '0;
			else term_q <= {9'd0, pred_q, 1'b0};
		end else if (cmd.term) begin
			term_q <= tval[TERM_W] ? '0 : TERM_W'({tval[TERM_W-1:0], 1'b0});
		end
		if (cmd.acc && last_q) begin
			tot_q <= sum_nx;
			sat_q <= ovf_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.acc) begin
			sum_q <= last_q ? '0 : sum_nx;
			ovf_q <= last_q ? 1'b0 : ovf_nx;
		end
	end

	assign total_deviance = tot_q;
	assign saturated      = sat_q;

endmodule

FILE: rtl/pda_ctrl.sv
`timescale 1ns / 1ps
module pda_ctrl import pda_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  pda_status_t status,
	output pda_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_LNO1, ST_LNO2, ST_LNP1, ST_LNP2, ST_MUL, ST_TERM, ST_ACC
	} state_t;

	state_t state_q;
	logic   valid_q;
	logic   acc_go;

	assign acc_go    = !(status.last && valid_q && !out_ready);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = valid_q;

	// command decode
	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == ST_IDLE) && in_valid;
		cmd.check = (state_q == ST_CHECK);
		cmd.ln1   = (state_q == ST_LNO1) || (state_q == ST_LNP1);
		cmd.ln2   = (state_q == ST_LNO2) || (state_q == ST_LNP2);
		cmd.sel_p = (state_q == ST_LNP1) || (state_q == ST_LNP2);
		cmd.mul   = (state_q == ST_MUL);
		cmd.term  = (state_q == ST_TERM);
		cmd.acc   = (state_q == ST_ACC) && acc_go;
	end

	// sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_ACC) && acc_go && status.last) valid_q <= 1'b1;
			else if (valid_q && out_ready) valid_q <= 1'b0;
			case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_CHECK;
				ST_CHECK: state_q <= status.bypass ? ST_ACC : ST_LNO1;
				ST_LNO1:  state_q <= ST_LNO2;
				ST_LNO2:  state_q <= ST_LNP1;
				ST_LNP1:  state_q <= ST_LNP2;
				ST_LNP2:  state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_TERM;
				ST_TERM:  state_q <= ST_ACC;
				ST_ACC: begin
					if (acc_go) state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
